/* src/rwr_pkg.sv */
// Package for the reorder window receiver: window size, slot entry type and the
// control bundle passed from the sequencer to the slot store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rwr_pkg;

    // Number of reorder slots; the slot of a sequence is its value modulo this.
    localparam int unsigned WINDOW_SLOTS = 16;
    localparam int unsigned SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    // Wide enough to hold the window size itself (deliveries per item).
    localparam int unsigned CNT_W = $clog2(WINDOW_SLOTS + 1);

    localparam int unsigned SEQ_W = 32;
    localparam int unsigned MAGIC_W = 32;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned LENGTH_W = 11;

    // Result kinds carried on the output tuser.
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK = 1'b1;

    // Register map (byte addresses).
    localparam logic [2:0] REG_EXPECTED_MAGIC = 3'd0;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } slot_entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_idx;
        slot_entry_t       wr_entry;
        logic              vld_en;
        logic [SLOT_W-1:0] vld_idx;
        logic              vld_val;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
    } slot_ctl_t;

endpackage

`default_nettype wire

/* src/rwr_slot_store.sv */
// Slot store of the reorder window: a synchronous memory of slot entries with a
// registered read, plus one valid flip-flop per slot. Uses rwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rwr_slot_store
    import rwr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire slot_ctl_t   ctl,
    output slot_entry_t      rd_entry,
    output logic             rd_valid
);

    slot_entry_t slot_mem [WINDOW_SLOTS];
    slot_entry_t rd_entry_reg;
    logic [WINDOW_SLOTS-1:0] valid_reg;
    logic rd_valid_reg;

    // Entries hold no reset value; they are only looked at while valid.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            slot_mem[ctl.wr_idx] <= ctl.wr_entry;
        end
        if (ctl.rd_en)
        begin
            rd_entry_reg <= slot_mem[ctl.rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.vld_en)
            begin
                valid_reg[ctl.vld_idx] <= ctl.vld_val;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctl.rd_idx];
            end
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

/* src/reorder_window_receiver_unit.sv */
// Top level of the reorder window receiver: stream input of packet descriptors,
// stream output of deliveries and acknowledgements, APB register port. Uses
// rwr_pkg and rwr_slot_store.
// Packet descriptors enter on the s_axis channel, one item per handshake. An
// item whose magic word differs from the expected_magic register, or any item
// after an accepted end-of-file item, is taken and dropped without results.
// An accepted out-of-order item is stored in its slot if its checksum passed;
// others clear their slot. A good item with the expected sequence is delivered,
// followed by every stored packet with consecutive sequence numbers, up to the
// window size in all. Each accepted item ends with one cumulative
// acknowledgement, marked by m_axis_tlast.
// One item at a time: an item goes through acceptance, the in-order delivery,
// each stored packet of the run (its slot read ahead of it), a read of the slot
// that ends the run (not when the whole window drains) and the ack; an item
// that delivers nothing goes straight to the ack. Results leave
// through an output register, so a new item may be accepted while the last
// acknowledgement still waits for m_axis_tready. When the receiver stalls, the
// sequencer holds its place (and the registered read data) until the output
// register frees up; nothing is lost. Reset clears the expected sequence, the
// end-of-file flag, every slot valid bit and the magic register.
`timescale 1ns / 1ps
`default_nettype none

module reorder_window_receiver_unit
    import rwr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] seq_number, [63:32] magic_word, [79:64] payload_handle,
    // [90:80] payload_length, [95:91] zero
    input  wire logic [95:0] s_axis_tdata,
    // [0] checksum_ok
    input  wire logic        s_axis_tuser,
    // end_of_file
    input  wire logic        s_axis_tlast,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] deliver_seq, [47:32] deliver_handle, [58:48] deliver_length,
    // [90:59] ack_seq, [91] ack_eof, [95:92] zero
    output logic [95:0]      m_axis_tdata,
    // [0] result_kind
    output logic             m_axis_tuser,
    // last_result
    output logic             m_axis_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FIRST = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_ACK   = 4'b1000
    } state_t;

    // Input fields.
    logic [SEQ_W-1:0]    in_seq;
    logic [MAGIC_W-1:0]  in_magic;
    logic [HANDLE_W-1:0] in_handle;
    logic [LENGTH_W-1:0] in_length;
    logic                in_ok;
    logic                in_eof;
    logic [SLOT_W-1:0]   in_idx;
    logic                in_order;

    assign in_seq    = s_axis_tdata[31:0];
    assign in_magic  = s_axis_tdata[63:32];
    assign in_handle = s_axis_tdata[79:64];
    assign in_length = s_axis_tdata[90:80];
    assign in_ok     = s_axis_tuser;
    assign in_eof    = s_axis_tlast;

    // Control and working registers.
    state_t              state_reg, state_next;
    logic [SEQ_W-1:0]    expected_seq_reg, expected_seq_next;
    logic                finished_reg, finished_next;
    logic [CNT_W-1:0]    drain_cnt_reg, drain_cnt_next;
    logic [MAGIC_W-1:0]  magic_reg;
    // Latched item fields, used for the in-order delivery and the ack.
    logic [SEQ_W-1:0]    item_seq_reg, item_seq_next;
    logic [HANDLE_W-1:0] item_handle_reg, item_handle_next;
    logic [LENGTH_W-1:0] item_length_reg, item_length_next;
    logic                item_eof_reg, item_eof_next;

    // Output register.
    logic                out_valid_reg;
    logic [95:0]         out_data_reg;
    logic                out_kind_reg;
    logic                out_last_reg;
    logic                out_free;
    logic                emit;
    logic [95:0]         emit_data;
    logic                emit_kind;
    logic                emit_last;

    // Slot store interface.
    slot_ctl_t           slot_ctl;
    slot_entry_t         rd_entry;
    logic                rd_valid;

    logic [SEQ_W-1:0]    exp_plus1;
    logic [SLOT_W-1:0]   exp_idx;
    logic [SLOT_W-1:0]   exp_plus1_idx;
    logic [CNT_W-1:0]    cnt_plus1;
    logic                drain_hit;
    logic                s_accept;
    logic                cfg_write;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign exp_plus1     = expected_seq_reg + 32'd1;
    assign exp_idx       = SLOT_W'(expected_seq_reg % WINDOW_SLOTS);
    assign exp_plus1_idx = SLOT_W'(exp_plus1 % WINDOW_SLOTS);
    assign in_idx        = SLOT_W'(in_seq % WINDOW_SLOTS);
    assign in_order      = (in_seq == expected_seq_reg);
    assign cnt_plus1     = drain_cnt_reg + CNT_W'(1);
    // The slot last read continues the run if it holds the expected sequence.
    assign drain_hit     = rd_valid && (rd_entry.seq == expected_seq_reg);

    rwr_slot_store u_slot_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (slot_ctl),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    // Sequencer: accept, deliver the in-order packet, drain the window, ack.
    always_comb
    begin
        state_next        = state_reg;
        expected_seq_next = expected_seq_reg;
        finished_next     = finished_reg;
        drain_cnt_next    = drain_cnt_reg;
        item_seq_next     = item_seq_reg;
        item_handle_next  = item_handle_reg;
        item_length_next  = item_length_reg;
        item_eof_next     = item_eof_reg;
        slot_ctl          = '0;
        emit              = 1'b0;
        emit_data         = '0;
        emit_kind         = KIND_DELIVER;
        emit_last         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && !finished_reg && (in_magic == magic_reg))
                begin
                    item_seq_next    = in_seq;
                    item_handle_next = in_handle;
                    item_length_next = in_length;
                    item_eof_next    = in_eof;
                    // A good packet is stored; an in-order one is delivered at
                    // once, so its slot ends up free.
                    slot_ctl.wr_en          = in_ok;
                    slot_ctl.wr_idx         = in_idx;
                    slot_ctl.wr_entry.seq    = in_seq;
                    slot_ctl.wr_entry.handle = in_handle;
                    slot_ctl.wr_entry.length = in_length;
                    slot_ctl.vld_en         = 1'b1;
                    slot_ctl.vld_idx        = in_idx;
                    slot_ctl.vld_val        = in_ok && !in_order;
                    state_next = (in_ok && in_order) ? ST_FIRST : ST_ACK;
                end
            end
            ST_FIRST:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    emit_data[31:0]   = item_seq_reg;
                    emit_data[47:32]  = item_handle_reg;
                    emit_data[58:48]  = item_length_reg;
                    expected_seq_next = exp_plus1;
                    drain_cnt_next    = CNT_W'(1);
                    if (CNT_W'(1) == CNT_W'(WINDOW_SLOTS))
                    begin
                        state_next = ST_ACK;
                    end
                    else
                    begin
                        slot_ctl.rd_en  = 1'b1;
                        slot_ctl.rd_idx = exp_plus1_idx;
                        state_next      = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (!drain_hit)
                begin
                    state_next = ST_ACK;
                end
                else if (out_free)
                begin
                    emit              = 1'b1;
                    emit_data[31:0]   = rd_entry.seq;
                    emit_data[47:32]  = rd_entry.handle;
                    emit_data[58:48]  = rd_entry.length;
                    slot_ctl.vld_en   = 1'b1;
                    slot_ctl.vld_idx  = exp_idx;
                    slot_ctl.vld_val  = 1'b0;
                    expected_seq_next = exp_plus1;
                    drain_cnt_next    = cnt_plus1;
                    if (cnt_plus1 == CNT_W'(WINDOW_SLOTS))
                    begin
                        state_next = ST_ACK;
                    end
                    else
                    begin
                        // Fetch the following slot while this one is emitted.
                        slot_ctl.rd_en  = 1'b1;
                        slot_ctl.rd_idx = exp_plus1_idx;
                    end
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    emit_kind        = KIND_ACK;
                    emit_last        = 1'b1;
                    emit_data[90:59] = expected_seq_reg - 32'd1;
                    emit_data[91]    = item_eof_reg;
                    finished_next    = finished_reg || item_eof_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            expected_seq_reg <= '0;
            finished_reg     <= 1'b0;
            drain_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
            magic_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            expected_seq_reg <= expected_seq_next;
            finished_reg     <= finished_next;
            drain_cnt_reg    <= drain_cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                magic_reg <= pwdata;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        item_seq_reg    <= item_seq_next;
        item_handle_reg <= item_handle_next;
        item_length_reg <= item_length_next;
        item_eof_reg    <= item_eof_next;
        if (emit)
        begin
            out_data_reg <= emit_data;
            out_kind_reg <= emit_kind;
            out_last_reg <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // Register port: a single register, decoded on the word address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_EXPECTED_MAGIC[2]);
    assign prdata    = (paddr[2] == REG_EXPECTED_MAGIC[2]) ? magic_reg : 32'd0;

`ifndef SYNTHESIS
    // The number of deliveries for one item never passes the window size.
    assert property (@(posedge clk) disable iff (!rst_n)
        drain_cnt_reg <= CNT_W'(WINDOW_SLOTS))
        else $error("drain count beyond window size");

    // The expected sequence moves only while a delivery is emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(expected_seq_reg) |-> $past(emit)
            && ($past(state_reg) == ST_FIRST || $past(state_reg) == ST_CHECK))
        else $error("expected sequence changed outside a delivery");

    // Once finished, an accepted item starts no work.
    assert property (@(posedge clk) disable iff (!rst_n)
        (finished_reg && s_accept) |=> (state_reg == ST_IDLE))
        else $error("item processed after end of file");

    // Only the acknowledgement closes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (emit_last == (emit_kind == KIND_ACK)))
        else $error("last flag does not match result kind");

    // A drained slot must hold exactly the expected sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && state_reg == ST_CHECK) |-> (emit_data[31:0] == expected_seq_reg))
        else $error("drained packet out of order");
`endif

endmodule

`default_nettype wire
